// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define MNP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds during reset
`define MNP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mnp_pkg.sv =====
`default_nettype none

package mnp_pkg;

    localparam logic [7:0] KEYDOWN_STATUS = 8'h90;
    localparam logic [6:0] PIANO_BASE     = 7'd21;

    localparam logic [1:0] STATUS_IGNORED  = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CELL_RD,
        S_CELL_WR,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic cell_rd;
        logic cell_wr;
        logic scan_init;
        logic scan_rd;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic work;
        logic clr_last;
        logic scan_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/markov_next_note_predictor.sv =====
// channel   | signals                              | handshake
// ----------+--------------------------------------+--------------------------------
// request   | event_type, note_number              | taken when start & !busy
// result    | status, prediction_valid, predicted_ | valid for one cycle with done
//           | key, scored, hit, total_scored/_hits |
//
// after reset all KEY_COUNT*KEY_COUNT table entries (7744 at defaults) are swept to
// zero, one entry a cycle, with busy high
// ignored, out-of-range or first key: S_DECODE, then S_RESULT, which registers done
// keyed update: S_DECODE, S_CELL_RD, S_CELL_WR, row scan in S_SCAN, S_DRAIN, S_RESULT
// a new request can be taken in the cycle done is shown; done cannot be held off
`default_nettype none

module markov_next_note_predictor #(
    parameter int KEY_COUNT  = 88,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  event_type,
    input  logic [6:0]  note_number,
    output logic        done,
    output logic [1:0]  status,
    output logic        prediction_valid,
    output logic [6:0]  predicted_key,
    output logic        scored,
    output logic        hit,
    output logic [31:0] total_scored,
    output logic [31:0] total_hits
);
    import mnp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mnp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mnp_datapath #(
        .KEY_COUNT  (KEY_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .event_type       (event_type),
        .note_number      (note_number),
        .done             (done),
        .status           (status),
        .prediction_valid (prediction_valid),
        .predicted_key    (predicted_key),
        .scored           (scored),
        .hit              (hit),
        .total_scored     (total_scored),
        .total_hits       (total_hits)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mnp_ctrl.sv =====
`default_nettype none

module mnp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mnp_pkg::dp_stat_t stat,
    output mnp_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import mnp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // addresses settle during this cycle
                state_next = stat.work ? S_CELL_RD : S_RESULT;
            end
            S_CELL_RD:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = S_CELL_WR;
            end
            S_CELL_WR:
            begin
                cmd.cell_wr   = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last compare lands here
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/mnp_datapath.sv =====
`default_nettype none

module mnp_datapath #(
    parameter int KEY_COUNT  = 88,
    parameter int COUNT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mnp_pkg::dp_cmd_t  cmd,
    output mnp_pkg::dp_stat_t stat,
    input  logic [7:0]        event_type,
    input  logic [6:0]        note_number,
    output logic              done,
    output logic [1:0]        status,
    output logic              prediction_valid,
    output logic [6:0]        predicted_key,
    output logic              scored,
    output logic              hit,
    output logic [31:0]       total_scored,
    output logic [31:0]       total_hits
);
    import mnp_pkg::*;

    localparam int DEPTH = KEY_COUNT * KEY_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(KEY_COUNT);

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic [7:0]      type_reg;
    logic [6:0]      note_reg;
    logic [AW-1:0]   cell_addr_reg;
    logic [AW-1:0]   row_base_reg;
    logic [AW-1:0]   clr_addr_reg;
    logic [AW-1:0]   scan_addr;
    logic [IW-1:0]   scan_idx_reg;
    logic [IW-1:0]   cmp_idx_reg;
    logic            cmp_valid_reg;

    logic [COUNT_BITS-1:0] best_reg,     best_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next;
    logic                  tie_reg,      tie_next;

    logic [6:0]  last_key_reg,     last_key_next;
    logic        last_valid_reg,   last_valid_next;
    logic        pending_reg,      pending_next;
    logic [6:0]  pending_key_reg,  pending_key_next;
    logic [31:0] scored_cnt_reg,   scored_cnt_next;
    logic [31:0] hit_cnt_reg,      hit_cnt_next;
    logic        done_reg;

    logic [1:0]  status_reg,     status_next;
    logic        pred_valid_reg, pred_valid_next;
    logic [6:0]  pred_key_reg,   pred_key_next;
    logic        scored_reg,     scored_next;
    logic        hit_reg,        hit_next;

    logic                  keydown;
    logic                  in_range;
    logic                  accepted;
    logic                  work;
    logic [7:0]            diff;
    logic [6:0]            key;
    logic [COUNT_BITS-1:0] cell_inc;

    assign keydown  = (type_reg == KEYDOWN_STATUS);
    assign diff     = {1'b0, note_reg} - {1'b0, PIANO_BASE};
    assign in_range = (note_reg >= PIANO_BASE) && (diff < 8'(KEY_COUNT));
    assign key      = diff[6:0];
    assign accepted = keydown && in_range;
    assign work     = accepted && last_valid_reg;

    assign stat.work      = work;
    assign stat.clr_last  = (clr_addr_reg == AW'(DEPTH - 1));
    assign stat.scan_last = (scan_idx_reg == IW'(KEY_COUNT - 1));

    assign scan_addr = row_base_reg + AW'(scan_idx_reg);
    assign cell_inc  = (&rd_data_reg) ? rd_data_reg : rd_data_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg <= event_type;
            note_reg <= note_number;
        end
        cell_addr_reg <= AW'(last_key_reg) * AW'(KEY_COUNT) + AW'(key);
        row_base_reg  <= AW'(key) * AW'(KEY_COUNT);
        cmp_idx_reg   <= scan_idx_reg;
    end

    // count table, cleared by a sweep after reset
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.cell_wr)
        begin
            mem[cell_addr_reg] <= cell_inc;
        end
        if (cmd.cell_rd)
        begin
            rd_data_reg <= mem[cell_addr_reg];
        end
        else if (cmd.scan_rd)
        begin
            rd_data_reg <= mem[scan_addr];
        end
    end

    always_comb
    begin
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        tie_next      = tie_reg;
        if (cmd.scan_init)
        begin
            best_next     = '0;
            best_idx_next = '0;
            tie_next      = 1'b0;
        end
        else if (cmp_valid_reg)
        begin
            if (rd_data_reg > best_reg)
            begin
                best_next     = rd_data_reg;
                best_idx_next = cmp_idx_reg;
                tie_next      = 1'b0;
            end
            else if (rd_data_reg == best_reg)
            begin
                tie_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        last_key_next    = last_key_reg;
        last_valid_next  = last_valid_reg;
        pending_next     = pending_reg;
        pending_key_next = pending_key_reg;
        scored_cnt_next  = scored_cnt_reg;
        hit_cnt_next     = hit_cnt_reg;
        status_next      = status_reg;
        pred_valid_next  = pred_valid_reg;
        pred_key_next    = pred_key_reg;
        scored_next      = scored_reg;
        hit_next         = hit_reg;
        if (cmd.finish)
        begin
            if (!keydown)
            begin
                status_next = STATUS_IGNORED;
            end
            else if (!in_range)
            begin
                status_next = STATUS_RANGE;
            end
            else
            begin
                status_next = STATUS_ACCEPTED;
            end
            pred_valid_next = work && !tie_reg;
            pred_key_next   = (work && !tie_reg) ? 7'(best_idx_reg) : 7'd0;
            scored_next     = work && pending_reg;
            hit_next        = work && pending_reg && (pending_key_reg == key);
            scored_cnt_next = scored_cnt_reg + 32'(work && pending_reg);
            hit_cnt_next    = hit_cnt_reg
                              + 32'(work && pending_reg && (pending_key_reg == key));
            if (work)
            begin
                pending_next = !tie_reg;
                if (!tie_reg)
                begin
                    pending_key_next = 7'(best_idx_reg);
                end
            end
            if (accepted)
            begin
                last_key_next   = key;
                last_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        pred_valid_reg <= pred_valid_next;
        pred_key_reg   <= pred_key_next;
        scored_reg     <= scored_next;
        hit_reg        <= hit_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        tie_reg        <= tie_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg    <= '0;
            scan_idx_reg    <= '0;
            cmp_valid_reg   <= 1'b0;
            last_key_reg    <= '0;
            last_valid_reg  <= 1'b0;
            pending_reg     <= 1'b0;
            pending_key_reg <= '0;
            scored_cnt_reg  <= '0;
            hit_cnt_reg     <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.scan_init)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            cmp_valid_reg   <= cmd.scan_rd;
            last_key_reg    <= last_key_next;
            last_valid_reg  <= last_valid_next;
            pending_reg     <= pending_next;
            pending_key_reg <= pending_key_next;
            scored_cnt_reg  <= scored_cnt_next;
            hit_cnt_reg     <= hit_cnt_next;
            done_reg        <= cmd.finish;
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign prediction_valid = pred_valid_reg;
    assign predicted_key    = pred_key_reg;
    assign scored           = scored_reg;
    assign hit              = hit_reg;
    assign total_scored     = scored_cnt_reg;
    assign total_hits       = hit_cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mnp_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module mnp_assert_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [7:0]  event_type,
    input logic [6:0]  note_number,
    input logic        done,
    input logic [1:0]  status,
    input logic        prediction_valid,
    input logic [6:0]  predicted_key,
    input logic        scored,
    input logic        hit,
    input logic [31:0] total_scored,
    input logic [31:0] total_hits
);
    import mnp_pkg::*;

    `MNP_ASSERT_ALWAYS(a_done_single, done |=> !done, "done held for more than one cycle")

    `MNP_ASSERT(a_accept_busy, start && !busy |=> busy, "request taken but busy not raised")

    `MNP_ASSERT(a_done_idle, done |-> !busy, "result shown while still busy")

    `MNP_ASSERT(a_skip_quiet, done && (status != STATUS_ACCEPTED) |-> !prediction_valid && !scored && !hit, "skipped request reports prediction or score")

    `MNP_ASSERT(a_totals_hold, done && !scored |-> (total_scored == $past(total_scored)) && (total_hits == $past(total_hits)), "totals moved without a score")

endmodule

bind markov_next_note_predictor mnp_assert_checker u_mnp_checker (.*);

`default_nettype wire

// ===== tb/mnp_checker.sv =====
`timescale 1ns / 100ps

module mnp_checker
    import mnp_pkg::*;
#(
    parameter int KEY_COUNT  = 88,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  event_type,
    input  logic [6:0]  note_number,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic        prediction_valid,
    input  logic [6:0]  predicted_key,
    input  logic        scored,
    input  logic        hit,
    input  logic [31:0] total_scored,
    input  logic [31:0] total_hits,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic [1:0]  status;
        logic        pred_valid;
        logic [6:0]  pred_key;
        logic        scored;
        logic        hit;
        logic [31:0] total_scored;
        logic [31:0] total_hits;
    } note_outcome_t;

    logic [COUNT_BITS-1:0] transitions [KEY_COUNT][KEY_COUNT];
    logic [6:0]            prev_key;
    logic                  prev_valid;
    logic                  guess_live;
    logic [6:0]            guess_key;
    logic [31:0]           n_scored;
    logic [31:0]           n_hits;
    note_outcome_t         outcome_q[$];
    note_outcome_t         want;

    task automatic report_mismatch(input string msg);
        errors = errors + 1;
        // keep the log short when the block is badly broken
        if (errors <= 100)
            $display("%0t mnp_checker: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
    endtask

    // advances the transition table and scoring for one request
    task automatic apply_event(input logic [7:0] ev, input logic [6:0] nn);
        note_outcome_t         o;
        int                    key;
        int                    best_idx;
        logic [COUNT_BITS-1:0] best;
        logic                  tie;
        o = '{default: '0};
        if (ev != KEYDOWN_STATUS) begin
            o.status = STATUS_IGNORED;
        end else begin
            key = int'(nn) - int'(PIANO_BASE);
            if (key < 0 || key >= KEY_COUNT) begin
                o.status = STATUS_RANGE;
            end else begin
                o.status = STATUS_ACCEPTED;
                if (prev_valid) begin
                    // saturating count
                    if (transitions[prev_key][key] != '1)
                        transitions[prev_key][key] = transitions[prev_key][key] + 1'b1;
                    if (guess_live) begin
                        o.scored = 1'b1;
                        n_scored = n_scored + 1;
                        if (guess_key == 7'(key)) begin
                            o.hit  = 1'b1;
                            n_hits = n_hits + 1;
                        end
                        guess_live = 1'b0;
                    end
                    best     = '0;
                    best_idx = 0;
                    tie      = 1'b0;
                    // zero entries at the head of the row count as a tie with best = 0
                    for (int i = 0; i < KEY_COUNT; i++) begin
                        if (transitions[key][i] > best) begin
                            best     = transitions[key][i];
                            best_idx = i;
                            tie      = 1'b0;
                        end else if (transitions[key][i] == best) begin
                            tie = 1'b1;
                        end
                    end
                    if (!tie) begin
                        guess_live   = 1'b1;
                        guess_key    = 7'(best_idx);
                        o.pred_valid = 1'b1;
                        o.pred_key   = guess_key;
                    end
                end
                prev_key   = 7'(key);
                prev_valid = 1'b1;
            end
        end
        o.total_scored = n_scored;
        o.total_hits   = n_hits;
        outcome_q.push_back(o);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_COUNT; i++)
                for (int j = 0; j < KEY_COUNT; j++)
                    transitions[i][j] = '0;
            prev_key   = '0;
            prev_valid = 1'b0;
            guess_live = 1'b0;
            guess_key  = '0;
            n_scored   = '0;
            n_hits     = '0;
            outcome_q.delete();
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            // a result shown now belongs to an earlier request
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = outcome_q.pop_front();
                    cmp_field("status", 32'(status), 32'(want.status));
                    cmp_field("prediction_valid", 32'(prediction_valid),
                              32'(want.pred_valid));
                    cmp_field("predicted_key", 32'(predicted_key), 32'(want.pred_key));
                    cmp_field("scored", 32'(scored), 32'(want.scored));
                    cmp_field("hit", 32'(hit), 32'(want.hit));
                    cmp_field("total_scored", total_scored, want.total_scored);
                    cmp_field("total_hits", total_hits, want.total_hits);
                end
            end
            if (start && !busy)
                apply_event(event_type, note_number);
            pending = outcome_q.size();
        end
    end

endmodule

// ===== tb/tb_markov_next_note_predictor.sv =====
`timescale 1ns / 100ps

module tb_markov_next_note_predictor;

    import mnp_pkg::*;

    localparam int KEY_COUNT    = 88;
    // narrow counters so saturation is reached within the run
    localparam int COUNT_BITS   = 4;
    localparam int ITEM_COUNT   = 900;
    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam logic [7:0] NOTE_OFF_STATUS = 8'h80;
    localparam logic [6:0] TOP_NOTE = 7'(PIANO_BASE + KEY_COUNT - 1);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  event_type = '0;
    logic [6:0]  note_number = '0;
    logic        done;
    logic [1:0]  status;
    logic        prediction_valid;
    logic [6:0]  predicted_key;
    logic        scored;
    logic        hit;
    logic [31:0] total_scored;
    logic [31:0] total_hits;

    int chk_errors;
    int chk_pending;
    int cycles = 0;
    int idle_mode = 1;

    always #2 clk = ~clk;

    markov_next_note_predictor #(
        .KEY_COUNT  (KEY_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .event_type       (event_type),
        .note_number      (note_number),
        .done             (done),
        .status           (status),
        .prediction_valid (prediction_valid),
        .predicted_key    (predicted_key),
        .scored           (scored),
        .hit              (hit),
        .total_scored     (total_scored),
        .total_hits       (total_hits)
    );

    mnp_checker #(
        .KEY_COUNT  (KEY_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .event_type       (event_type),
        .note_number      (note_number),
        .done             (done),
        .status           (status),
        .prediction_valid (prediction_valid),
        .predicted_key    (predicted_key),
        .scored           (scored),
        .hit              (hit),
        .total_scored     (total_scored),
        .total_hits       (total_hits),
        .errors           (chk_errors),
        .pending          (chk_pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_markov_next_note_predictor: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (idle_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 30);
        return $urandom_range(40, 200);
    endfunction

    // returns at the rising edge where the request is taken
    task automatic send_request(input logic [7:0] ev, input logic [6:0] nn);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start       <= 1'b1;
        event_type  <= ev;
        note_number <= nn;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          pool[6];
        int          pool_n;
        int          idx;
        int          r;
        int          sent;
        int          phase_len;
        logic [7:0]  ev;
        logic [6:0]  nn;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // ignored status bytes and out-of-range notes
        send_request(NOTE_OFF_STATUS, 7'd60);
        send_request(8'h00, 7'd0);
        send_request(8'hFF, 7'd127);
        send_request(KEYDOWN_STATUS, 7'd0);
        send_request(KEYDOWN_STATUS, 7'(PIANO_BASE - 1));
        send_request(KEYDOWN_STATUS, 7'(TOP_NOTE + 1));
        send_request(KEYDOWN_STATUS, 7'd127);
        // first key, then lowest and highest keys trading predictions, two non-keydown statuses
        send_request(KEYDOWN_STATUS, PIANO_BASE);
        send_request(KEYDOWN_STATUS, TOP_NOTE);
        send_request(KEYDOWN_STATUS, PIANO_BASE);
        send_request(KEYDOWN_STATUS, TOP_NOTE);
        send_request(KEYDOWN_STATUS | 8'h01, PIANO_BASE);
        send_request(KEYDOWN_STATUS ^ 8'h80, PIANO_BASE);
        send_request(KEYDOWN_STATUS, PIANO_BASE);
        // miss, then a self transition repeated
        repeat (5) send_request(KEYDOWN_STATUS, 7'd60);
        // two equal maxima in one row
        send_request(KEYDOWN_STATUS, 7'd61);
        send_request(KEYDOWN_STATUS, 7'd62);
        send_request(KEYDOWN_STATUS, 7'd61);
        send_request(KEYDOWN_STATUS, 7'd63);
        send_request(KEYDOWN_STATUS, 7'd61);

        sent = 24;
        while (sent < ITEM_COUNT)
        begin
            idle_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
            pool_n = $urandom_range(2, 6);
            for (int k = 0; k < 6; k++)
                pool[k] = $urandom_range(0, KEY_COUNT - 1);
            if ($urandom_range(0, 5) == 0)
                pool[0] = 0;
            if ($urandom_range(0, 5) == 0)
                pool[pool_n - 1] = KEY_COUNT - 1;
            idx = 0;
            phase_len = $urandom_range(20, 60);
            repeat (phase_len)
            begin
                r = $urandom_range(0, 99);
                if (r < 78)
                begin
                    // mostly a cycle through the pool, so predictions get hits
                    if ($urandom_range(0, 2) != 0)
                        idx = (idx + 1) % pool_n;
                    else
                        idx = $urandom_range(0, pool_n - 1);
                    ev = KEYDOWN_STATUS;
                    nn = 7'(pool[idx] + PIANO_BASE);
                end
                else if (r < 88)
                begin
                    ev = 8'($urandom);
                    nn = 7'($urandom);
                end
                else if (r < 94)
                begin
                    ev = KEYDOWN_STATUS;
                    if ($urandom_range(0, 1) == 0)
                        nn = 7'($urandom_range(0, PIANO_BASE - 1));
                    else
                        nn = 7'($urandom_range(TOP_NOTE + 1, 127));
                end
                else
                begin
                    ev = KEYDOWN_STATUS;
                    nn = 7'($urandom_range(PIANO_BASE, TOP_NOTE));
                end
                send_request(ev, nn);
                sent++;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (chk_pending != 0) @(negedge clk);
        repeat (KEY_COUNT + 16) @(negedge clk);
        if (chk_errors == 0)
            $display("tb_markov_next_note_predictor: PASS");
        else
            $display("tb_markov_next_note_predictor: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mnp_pkg.sv
rtl/core/mnp_ctrl.sv
rtl/core/mnp_datapath.sv
rtl/core/markov_next_note_predictor.sv
rtl/core/mnp_checker.sv
tb/mnp_checker.sv
tb/tb_markov_next_note_predictor.sv
